// File: rtl/core/rmq_pkg.sv
// shared types and constants for the rotation matrix to quaternion core
package rmq_pkg;

   localparam int ENTRY_W = 16;
   localparam int ARG_W   = 17;
   localparam int ROOT_W  = 9;
   localparam int SC_W    = 16;
   localparam int NUM_W   = 18;
   localparam int QUOT_W  = 19;
   localparam int REM_W   = 27;
   localparam int RECIP_SHIFT = 3;
   localparam int RECIP_W = QUOT_W + RECIP_SHIFT;
   localparam int PROD_W  = NUM_W + RECIP_W + 1;
   localparam int SQRT_STEPS = 9;

   localparam logic [7:0]       ROOT_SCALE = 8'd181;
   localparam logic [REM_W-1:0] RECIP_NUM  = REM_W'(1) << (14 + 12);
   localparam logic signed [19:0] QONE     = 20'sd32768;

   // pivot / path selector codes
   localparam logic [1:0] SEL_AXIS_X = 2'd0;
   localparam logic [1:0] SEL_AXIS_Y = 2'd1;
   localparam logic [1:0] SEL_AXIS_Z = 2'd2;
   localparam logic [1:0] SEL_TRACE  = 2'd3;

   typedef struct packed {
      logic signed [ENTRY_W-1:0] row0_col0;
      logic signed [ENTRY_W-1:0] row0_col1;
      logic signed [ENTRY_W-1:0] row0_col2;
      logic signed [ENTRY_W-1:0] row1_col0;
      logic signed [ENTRY_W-1:0] row1_col1;
      logic signed [ENTRY_W-1:0] row1_col2;
      logic signed [ENTRY_W-1:0] row2_col0;
      logic signed [ENTRY_W-1:0] row2_col1;
      logic signed [ENTRY_W-1:0] row2_col2;
   } req_type;

   typedef struct packed {
      logic signed [ENTRY_W-1:0] quat_x;
      logic signed [ENTRY_W-1:0] quat_y;
      logic signed [ENTRY_W-1:0] quat_z;
      logic signed [ENTRY_W-1:0] quat_w;
   } rsp_type;

   // side data that rides along the root and reciprocal stages
   typedef struct packed {
      logic [1:0]            sel;
      logic [3:0][NUM_W-1:0] num;
   } meta_type;

endpackage

// File: rtl/core/rotation_matrix_to_quaternion_q15_core.sv
// rotation matrix to q15 quaternion core, fully pipelined
// throughput: one matrix beat per cycle, busy is always low
// stages: input reg, prep, 9 root steps, scale, 19 quotient steps, multiply, output
// reset: synchronous active high, clears the valid bits only
// results cannot be held off, so the pipeline never stalls
module rotation_matrix_to_quaternion_q15_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rmq_pkg::req_type req_data,
   output logic             rsp_strobe,
   output rmq_pkg::rsp_type rsp_data
);

   localparam int SQ_N = rmq_pkg::SQRT_STEPS;
   localparam int DV_N = rmq_pkg::QUOT_W;
   localparam int NW   = rmq_pkg::NUM_W;

   assign busy = 1'b0;

   // input register
   rmq_pkg::req_type in_ff;
   logic             in_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= start & ~busy;
      end
      in_ff <= req_data;
   end

   // prep: trace, pivot, root argument and the three numerators
   logic signed [19:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
   logic signed [19:0] trace, arg_raw;
   logic [1:0]         piv;
   logic [rmq_pkg::ARG_W-1:0] arg_in;
   rmq_pkg::meta_type  meta_in;

   always_comb begin
      m00 = 20'(in_ff.row0_col0);
      m01 = 20'(in_ff.row0_col1);
      m02 = 20'(in_ff.row0_col2);
      m10 = 20'(in_ff.row1_col0);
      m11 = 20'(in_ff.row1_col1);
      m12 = 20'(in_ff.row1_col2);
      m20 = 20'(in_ff.row2_col0);
      m21 = 20'(in_ff.row2_col1);
      m22 = 20'(in_ff.row2_col2);
      trace = m00 + m11 + m22;
      piv = rmq_pkg::SEL_AXIS_X;
      if (m11 > m00) piv = rmq_pkg::SEL_AXIS_Y;
      if (m22 > ((piv == rmq_pkg::SEL_AXIS_Y) ? m11 : m00)) piv = rmq_pkg::SEL_AXIS_Z;
      meta_in.num = '0;
      if (trace > 20'sd0) begin
         meta_in.sel = rmq_pkg::SEL_TRACE;
         arg_raw = trace + rmq_pkg::QONE;
         meta_in.num[0] = NW'(m12 - m21);
         meta_in.num[1] = NW'(m20 - m02);
         meta_in.num[2] = NW'(m01 - m10);
      end else begin
         meta_in.sel = piv;
         case (piv)
            rmq_pkg::SEL_AXIS_X: begin
               arg_raw = m00 - (m11 + m22) + rmq_pkg::QONE;
               meta_in.num[3] = NW'(m12 - m21);
               meta_in.num[1] = NW'(m01 + m10);
               meta_in.num[2] = NW'(m02 + m20);
            end
            rmq_pkg::SEL_AXIS_Y: begin
               arg_raw = m11 - (m22 + m00) + rmq_pkg::QONE;
               meta_in.num[3] = NW'(m20 - m02);
               meta_in.num[2] = NW'(m12 + m21);
               meta_in.num[0] = NW'(m10 + m01);
            end
            default: begin
               arg_raw = m22 - (m00 + m11) + rmq_pkg::QONE;
               meta_in.num[3] = NW'(m01 - m10);
               meta_in.num[0] = NW'(m20 + m02);
               meta_in.num[1] = NW'(m21 + m12);
            end
         endcase
      end
      // negative argument clamps to zero
      arg_in = arg_raw[19] ? '0 : arg_raw[rmq_pkg::ARG_W-1:0];
   end

   // root pipeline, one digit pair per stage
   logic [rmq_pkg::ARG_W-1:0] sq_a_ff   [0:SQ_N];
   logic [17:0]               sq_r_ff   [0:SQ_N];
   rmq_pkg::meta_type         sq_m_ff   [0:SQ_N];
   logic                      sq_vld_ff [0:SQ_N];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff[0] <= 1'b0;
      end else begin
         sq_vld_ff[0] <= in_vld_ff;
      end
      sq_a_ff[0] <= arg_in;
      sq_r_ff[0] <= '0;
      sq_m_ff[0] <= meta_in;
   end

   for (genvar t = 0; t < SQ_N; t++) begin : g_sqrt
      localparam logic [17:0] BIT = 18'(1) << (2 * (SQ_N - 1 - t));
      logic [17:0] trial;
      logic        take;
      assign trial = sq_r_ff[t] + BIT;
      assign take  = {1'b0, sq_a_ff[t]} >= trial;
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[t+1] <= 1'b0;
         end else begin
            sq_vld_ff[t+1] <= sq_vld_ff[t];
         end
         if (take) begin
            sq_a_ff[t+1] <= sq_a_ff[t] - trial[rmq_pkg::ARG_W-1:0];
            sq_r_ff[t+1] <= (sq_r_ff[t] >> 1) + BIT;
         end else begin
            sq_a_ff[t+1] <= sq_a_ff[t];
            sq_r_ff[t+1] <= sq_r_ff[t] >> 1;
         end
         sq_m_ff[t+1] <= sq_m_ff[t];
      end
   end

   // scale the root by 181, then the quotient pipeline for 2^26 / s
   logic [rmq_pkg::ROOT_W-1:0] root;
   logic [16:0]                sc_full;
   assign root    = sq_r_ff[SQ_N][rmq_pkg::ROOT_W-1:0];
   assign sc_full = root * rmq_pkg::ROOT_SCALE;

   logic [rmq_pkg::REM_W-1:0]  dv_rem_ff [0:DV_N];
   logic [rmq_pkg::QUOT_W-1:0] dv_q_ff   [0:DV_N];
   logic [rmq_pkg::SC_W-1:0]   dv_sc_ff  [0:DV_N];
   rmq_pkg::meta_type          dv_m_ff   [0:DV_N];
   logic                       dv_vld_ff [0:DV_N];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff[0] <= 1'b0;
      end else begin
         dv_vld_ff[0] <= sq_vld_ff[SQ_N];
      end
      dv_rem_ff[0] <= rmq_pkg::RECIP_NUM;
      dv_q_ff[0]   <= '0;
      dv_sc_ff[0]  <= sc_full[rmq_pkg::SC_W-1:0];
      dv_m_ff[0]   <= sq_m_ff[SQ_N];
   end

   for (genvar d = 0; d < DV_N; d++) begin : g_div
      localparam int B = DV_N - 1 - d;
      logic [35:0] dsh;
      logic        take;
      assign dsh  = {20'b0, dv_sc_ff[d]} << B;
      assign take = {9'b0, dv_rem_ff[d]} >= dsh;
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[d+1] <= 1'b0;
         end else begin
            dv_vld_ff[d+1] <= dv_vld_ff[d];
         end
         dv_rem_ff[d+1] <= take ? dv_rem_ff[d] - dsh[rmq_pkg::REM_W-1:0] : dv_rem_ff[d];
         dv_q_ff[d+1]   <= dv_q_ff[d] | (rmq_pkg::QUOT_W'(take) << B);
         dv_sc_ff[d+1]  <= dv_sc_ff[d];
         dv_m_ff[d+1]   <= dv_m_ff[d];
      end
   end

   // multiply stage: numerators times the reciprocal, pivot gets s/2
   logic [rmq_pkg::RECIP_W-1:0] recip;
   assign recip = (dv_sc_ff[DV_N] == '0) ? '0
                : {dv_q_ff[DV_N], {rmq_pkg::RECIP_SHIFT{1'b0}}};

   logic signed [rmq_pkg::PROD_W-1:0] pr_ff [0:3];
   logic [rmq_pkg::SC_W-2:0]          half_ff;
   logic [1:0]                        pr_sel_ff;
   logic                              pr_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pr_vld_ff <= 1'b0;
      end else begin
         pr_vld_ff <= dv_vld_ff[DV_N];
      end
      for (int k = 0; k < 4; k++) begin
         pr_ff[k] <= $signed(dv_m_ff[DV_N].num[k]) * $signed({1'b0, recip});
      end
      half_ff   <= dv_sc_ff[DV_N][rmq_pkg::SC_W-1:1];
      pr_sel_ff <= dv_m_ff[DV_N].sel;
   end

   // output stage: floor shift by 15 and saturate, the pivot component takes s/2
   logic [3:0][15:0] comp;
   logic [1:0]       big;
   assign big = pr_sel_ff;

   always_comb begin
      logic signed [rmq_pkg::PROD_W-16:0] sh;
      for (int k = 0; k < 4; k++) begin
         sh = pr_ff[k][rmq_pkg::PROD_W-1:15];
         if (sh > 26'sd32767)       comp[k] = 16'h7fff;
         else if (sh < -26'sd32768) comp[k] = 16'h8000;
         else                       comp[k] = sh[15:0];
         if (2'(k) == big) comp[k] = {1'b0, half_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= pr_vld_ff;
      end
      rsp_data.quat_x <= comp[0];
      rsp_data.quat_y <= comp[1];
      rsp_data.quat_z <= comp[2];
      rsp_data.quat_w <= comp[3];
   end

   // the root never exceeds the square root of the widest argument
   a_root_range: assert property (@(posedge clock) disable iff (reset)
      sq_vld_ff[SQ_N] |-> (sq_r_ff[SQ_N] <= 18'd362))
      else $error("root out of range");

   // a zero scale gives zero products in the multiply stage
   a_zero_recip: assert property (@(posedge clock) disable iff (reset)
      (dv_vld_ff[DV_N] && dv_sc_ff[DV_N] == '0) |=>
      (pr_ff[0] == '0 && pr_ff[1] == '0 && pr_ff[2] == '0 && pr_ff[3] == '0))
      else $error("nonzero product with zero root");

   // a strobe follows a valid multiply stage
   a_strobe_src: assert property (@(posedge clock) disable iff (reset)
      pr_vld_ff |=> rsp_strobe)
      else $error("lost result beat");

endmodule
